// ===== sv/jar_fill_and_cap_station_sequencer_assert.svh =====
// Assertion macros for the jar fill and cap station sequencer.
// Included by the RTL file that carries concurrent checks; no dependencies.
`ifndef JAR_FILL_AND_CAP_STATION_SEQUENCER_ASSERT_SVH
`define JAR_FILL_AND_CAP_STATION_SEQUENCER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define JFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define JFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/jfc_pkg.sv =====
// Shared types and constants for the jar fill and cap station sequencer.
// No dependencies; imported by every module of the block and by jfc_rsp_if.
package jfc_pkg;

   localparam int unsigned CFG_INDEX_W = 3;
   localparam int unsigned CFG_DATA_W  = 16;
   localparam int unsigned AGE_W       = 16;
   localparam int unsigned POS_W       = 3;
   localparam int unsigned PHASE_CODE_W = 3;

   localparam int unsigned SET_SIZE_DEFAULT = 6;

   localparam logic [AGE_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [AGE_W-1:0] POLL_RESET     = 16'd100;
   localparam logic [AGE_W-1:0] PNEU_RESET     = 16'd500;
   localparam logic [AGE_W-1:0] EXTRUDE_RESET  = 16'd1000;

   // Register indexes on the csr port
   localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE      = 3'd0;
   localparam logic [CFG_INDEX_W-1:0] CFG_POLL          = 3'd1;
   localparam logic [CFG_INDEX_W-1:0] CFG_CENTERING     = 3'd2;
   localparam logic [CFG_INDEX_W-1:0] CFG_EXTRUDE       = 3'd3;
   localparam logic [CFG_INDEX_W-1:0] CFG_TWIST_FORWARD = 3'd4;
   localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_FORWARD = 3'd5;
   localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_BACK    = 3'd6;
   localparam logic [CFG_INDEX_W-1:0] CFG_TWIST_BACK    = 3'd7;

   // Station phase, one-hot
   typedef enum logic [6:0] {
      PH_IDLE       = 7'b0000001,
      PH_CENTER     = 7'b0000010,
      PH_EXTRUDE    = 7'b0000100,
      PH_TWIST_FWD  = 7'b0001000,
      PH_PRESS_FWD  = 7'b0010000,
      PH_PRESS_BACK = 7'b0100000,
      PH_TWIST_BACK = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [AGE_W-1:0] debounce_ticks;
      logic [AGE_W-1:0] poll_ticks;
      logic [AGE_W-1:0] centering_ticks;
      logic [AGE_W-1:0] extrude_ticks;
      logic [AGE_W-1:0] twist_forward_ticks;
      logic [AGE_W-1:0] press_forward_ticks;
      logic [AGE_W-1:0] press_back_ticks;
      logic [AGE_W-1:0] twist_back_ticks;
   } jfc_cfg_type;

   typedef struct packed {
      logic run_switch;
      logic mode_switch;
      logic nozzle_jar;
      logic press_jar;
   } jfc_req_type;

   typedef struct packed {
      logic                    motor_drive;
      logic                    twist_valve;
      logic                    press_valve;
      logic                    extruder_on;
      logic                    led_all_jars;
      logic                    led_first_only;
      logic                    machine_on;
      logic [PHASE_CODE_W-1:0] phase_code;
      logic [POS_W-1:0]        jar_index;
      logic [POS_W-1:0]        cap_index;
   } jfc_rsp_type;

   typedef struct packed {
      logic             run_level_seen;
      logic             mode_level_seen;
      logic             first_only;
      logic             running;
      logic             running_before;
      logic [AGE_W-1:0] run_lockout_age;
      logic [AGE_W-1:0] mode_lockout_age;
      logic [AGE_W-1:0] poll_age;
      logic             nozzle_busy_wait;
      logic             press_busy_wait;
      logic             press_check_owed;
      logic [POS_W-1:0] jar_position;
      logic [POS_W-1:0] cap_position;
      phase_type        phase;
      logic [AGE_W-1:0] phase_age;
   } jfc_state_type;

   localparam jfc_state_type STATE_RESET = '{
      run_level_seen:   1'b1,
      mode_level_seen:  1'b1,
      first_only:       1'b0,
      running:          1'b1,
      running_before:   1'b1,
      run_lockout_age:  '0,
      mode_lockout_age: '0,
      poll_age:         '0,
      nozzle_busy_wait: 1'b0,
      press_busy_wait:  1'b0,
      press_check_owed: 1'b0,
      jar_position:     '0,
      cap_position:     '0,
      phase:            PH_IDLE,
      phase_age:        '0
   };

endpackage

// ===== sv/jfc_req_if.sv =====
// Tick item channel (switch and sensor levels) with valid/ready handshake.
// Has no dependencies, not even on jfc_pkg; one item per accepted edge.
interface jfc_req_if;
   logic valid;
   logic ready;
   logic run_switch;
   logic mode_switch;
   logic nozzle_jar;
   logic press_jar;

   modport source (output valid, output run_switch, output mode_switch,
                   output nozzle_jar, output press_jar, input ready);
   modport sink   (input valid, input run_switch, input mode_switch,
                   input nozzle_jar, input press_jar, output ready);
endinterface

// Result item channel (actuator drives, lamps, phase and positions).
// Uses the field widths of jfc_pkg.
interface jfc_rsp_if import jfc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    motor_drive;
   logic                    twist_valve;
   logic                    press_valve;
   logic                    extruder_on;
   logic                    led_all_jars;
   logic                    led_first_only;
   logic                    machine_on;
   logic [PHASE_CODE_W-1:0] phase_code;
   logic [POS_W-1:0]        jar_index;
   logic [POS_W-1:0]        cap_index;

   modport source (output valid, output motor_drive, output twist_valve,
                   output press_valve, output extruder_on, output led_all_jars,
                   output led_first_only, output machine_on, output phase_code,
                   output jar_index, output cap_index, input ready);
   modport sink   (input valid, input motor_drive, input twist_valve,
                   input press_valve, input extruder_on, input led_all_jars,
                   input led_first_only, input machine_on, input phase_code,
                   input jar_index, input cap_index, output ready);
endinterface

// ===== sv/jfc_cfg_regs.sv =====
// Timing register file of the sequencer, written through the csr port.
// Depends on jfc_pkg for the register indexes, reset values and jfc_cfg_type.
module jfc_cfg_regs import jfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_data,
   output jfc_cfg_type            cfg
);

   jfc_cfg_type cfg_ff;

   // Load defaults at reset, take one register per write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
         cfg_ff.poll_ticks          <= POLL_RESET;
         cfg_ff.centering_ticks     <= PNEU_RESET;
         cfg_ff.extrude_ticks       <= EXTRUDE_RESET;
         cfg_ff.twist_forward_ticks <= PNEU_RESET;
         cfg_ff.press_forward_ticks <= PNEU_RESET;
         cfg_ff.press_back_ticks    <= PNEU_RESET;
         cfg_ff.twist_back_ticks    <= PNEU_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_DEBOUNCE:      cfg_ff.debounce_ticks      <= csr_data;
            CFG_POLL:          cfg_ff.poll_ticks          <= csr_data;
            CFG_CENTERING:     cfg_ff.centering_ticks     <= csr_data;
            CFG_EXTRUDE:       cfg_ff.extrude_ticks       <= csr_data;
            CFG_TWIST_FORWARD: cfg_ff.twist_forward_ticks <= csr_data;
            CFG_PRESS_FORWARD: cfg_ff.press_forward_ticks <= csr_data;
            CFG_PRESS_BACK:    cfg_ff.press_back_ticks    <= csr_data;
            CFG_TWIST_BACK:    cfg_ff.twist_back_ticks    <= csr_data;
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/jfc_step.sv =====
// Next-state and result logic for one tick item of the sequencer.
// Depends on jfc_pkg for the state, config, item and result types.
module jfc_step import jfc_pkg::*; #(
   parameter int unsigned SET_SIZE = SET_SIZE_DEFAULT
) (
   input  jfc_cfg_type   cfg,
   input  jfc_state_type cur,
   input  jfc_req_type   item,
   output jfc_state_type nxt,
   output jfc_rsp_type   result
);

   localparam logic [POS_W:0] SET_LIMIT = (POS_W+1)'(SET_SIZE);
   localparam logic [POS_W-1:0] FIRST_JAR_LIMIT = 3'd1;
   localparam logic [AGE_W-1:0] AGE_MAX = '1;
   localparam logic [AGE_W-1:0] MIN_DURATION = 16'd1;

   function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
      return (a != AGE_MAX) ? a + 1'b1 : AGE_MAX;
   endfunction

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
      logic [POS_W:0] n;
      n = {1'b0, p} + 1'b1;
      return (n >= SET_LIMIT) ? '0 : n[POS_W-1:0];
   endfunction

   function automatic logic [AGE_W-1:0] phase_duration(input jfc_cfg_type c,
                                                       input phase_type ph);
      case (ph)
         PH_CENTER:     return c.centering_ticks;
         PH_EXTRUDE:    return c.extrude_ticks;
         PH_TWIST_FWD:  return c.twist_forward_ticks;
         PH_PRESS_FWD:  return c.press_forward_ticks;
         PH_PRESS_BACK: return c.press_back_ticks;
         PH_TWIST_BACK: return c.twist_back_ticks;
         default:       return MIN_DURATION;
      endcase
   endfunction

   function automatic phase_type phase_after(input phase_type ph);
      case (ph)
         PH_CENTER:     return PH_EXTRUDE;
         PH_TWIST_FWD:  return PH_PRESS_FWD;
         PH_PRESS_FWD:  return PH_PRESS_BACK;
         PH_PRESS_BACK: return PH_TWIST_BACK;
         default:       return PH_IDLE;
      endcase
   endfunction

   function automatic logic [PHASE_CODE_W-1:0] phase_code(input phase_type ph);
      case (ph)
         PH_CENTER:     return 3'd1;
         PH_EXTRUDE:    return 3'd2;
         PH_TWIST_FWD:  return 3'd3;
         PH_PRESS_FWD:  return 3'd4;
         PH_PRESS_BACK: return 3'd5;
         PH_TWIST_BACK: return 3'd6;
         default:       return 3'd0;
      endcase
   endfunction

   // Start capping on a new press jar, first of each set only
   function automatic jfc_state_type press_check(input jfc_state_type st,
                                                 input logic jar);
      jfc_state_type r;
      r = st;
      if (!r.press_busy_wait && jar) begin
         if (r.cap_position == '0) begin
            r.phase     = PH_TWIST_FWD;
            r.phase_age = '0;
         end
         r.press_busy_wait = 1'b1;
         r.cap_position    = next_pos(r.cap_position);
      end
      if (r.press_busy_wait && !jar) begin
         r.press_busy_wait = 1'b0;
      end
      return r;
   endfunction

   jfc_state_type    work;
   logic [AGE_W-1:0] dur;
   logic             allow;

   always_comb begin
      work  = cur;
      dur   = phase_duration(cfg, cur.phase);
      allow = 1'b0;
      if (dur == '0) begin
         dur = MIN_DURATION;
      end

      if (cur.phase != PH_IDLE) begin
         // Timed phase: count, then hand over to the next phase
         work.phase_age = age_up(cur.phase_age);
         if (work.phase_age >= dur) begin
            work.phase_age = '0;
            case (cur.phase)
               PH_EXTRUDE: begin
                  work.phase = PH_IDLE;
                  if (work.press_check_owed) begin
                     work.press_check_owed = 1'b0;
                     work = press_check(work, item.press_jar);
                  end
               end
               PH_TWIST_BACK: work.phase = PH_IDLE;
               default:       work.phase = phase_after(cur.phase);
            endcase
         end
      end else begin
         // Debounced run switch
         if (item.run_switch != work.run_level_seen &&
             work.run_lockout_age > cfg.debounce_ticks) begin
            work.run_lockout_age = '0;
            work.run_level_seen  = item.run_switch;
            work.running         = item.run_switch;
         end
         // Debounced mode switch, only while stopped
         if (!work.running && item.mode_switch != work.mode_level_seen &&
             work.mode_lockout_age > cfg.debounce_ticks) begin
            work.mode_lockout_age = '0;
            work.mode_level_seen  = item.mode_switch;
            work.first_only       = item.mode_switch;
         end
         // Take the mode level over at the tick of stopping
         if (work.running_before && !work.running) begin
            work.first_only      = item.mode_switch;
            work.mode_level_seen = item.mode_switch;
         end
         work.running_before = work.running;

         // Sensor poll
         if (work.running && work.poll_age >= cfg.poll_ticks) begin
            work.poll_age = '0;
            if (!work.nozzle_busy_wait && item.nozzle_jar) begin
               allow = !(work.first_only && work.jar_position >= FIRST_JAR_LIMIT);
               if (allow) begin
                  work.phase            = PH_CENTER;
                  work.phase_age        = '0;
                  work.press_check_owed = 1'b1;
               end
               work.nozzle_busy_wait = 1'b1;
               work.jar_position     = next_pos(work.jar_position);
            end
            if (work.nozzle_busy_wait && !item.nozzle_jar) begin
               work.nozzle_busy_wait = 1'b0;
            end
            if (!work.press_check_owed) begin
               work = press_check(work, item.press_jar);
            end
         end
      end

      // Result from the settled state of this tick
      result.motor_drive    = (work.phase == PH_IDLE && work.running) ||
                              work.phase == PH_CENTER;
      result.twist_valve    = work.phase == PH_TWIST_FWD ||
                              work.phase == PH_PRESS_FWD ||
                              work.phase == PH_PRESS_BACK;
      result.press_valve    = work.phase == PH_PRESS_FWD;
      result.extruder_on    = work.phase == PH_EXTRUDE;
      result.led_all_jars   = !work.first_only;
      result.led_first_only = work.first_only;
      result.machine_on     = work.running;
      result.phase_code     = phase_code(work.phase);
      result.jar_index      = work.jar_position;
      result.cap_index      = work.cap_position;

      // Advance the saturating ages every tick
      nxt                  = work;
      nxt.run_lockout_age  = age_up(work.run_lockout_age);
      nxt.mode_lockout_age = age_up(work.mode_lockout_age);
      nxt.poll_age         = age_up(work.poll_age);
   end

endmodule

// ===== sv/jar_fill_and_cap_station_sequencer.sv =====
// Jar fill and cap station sequencer: one tick item in, one result item out.
// Channels: req_item takes one millisecond tick with the raw run and mode
//   switch levels and the nozzle and press jar sensors; rsp_item returns the
//   conveyor, valve and extruder drives, the mode lamps, the run state, the
//   phase code and the jar and cap positions within the set.
// csr_we/csr_index/csr_data write the eight timing registers; write them
//   only while no item is in flight.
// Path: an accepted tick item waits in the input register; its result then
//   goes to the result register. Throughput: one item per cycle unless
//   rsp_item is held off; the step logic updates the sequencer state and
//   loads the result register in the same cycle.
// Reset: the sequencer starts running, in all-jars mode, idle phase, both
//   positions at zero, all lockout and poll ages at zero, registers at their
//   default values. No clearing pass is needed.
// Stall: while rsp_item is held off the result register keeps its item and
//   the input register can still take one more; after that req_item.ready
//   drops until the receiver takes the waiting result.
// Depends on jfc_pkg, jfc_req_if/jfc_rsp_if, jfc_cfg_regs and jfc_step.
`include "jar_fill_and_cap_station_sequencer_assert.svh"

module jar_fill_and_cap_station_sequencer import jfc_pkg::*; #(
   parameter int unsigned SET_SIZE = SET_SIZE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   jfc_req_if.sink                req_item,
   jfc_rsp_if.source              rsp_item,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_data
);

   jfc_cfg_type   cfg;
   jfc_state_type state_ff;
   jfc_state_type state_in;
   jfc_req_type   in_item_ff;
   logic          in_valid_ff;
   jfc_rsp_type   step_rsp;
   jfc_rsp_type   out_item_ff;
   logic          out_valid_ff;
   logic          advance;
   logic          take_in;

   jfc_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jfc_step #(
      .SET_SIZE (SET_SIZE)
   ) u_step (
      .cfg    (cfg),
      .cur    (state_ff),
      .item   (in_item_ff),
      .nxt    (state_in),
      .result (step_rsp)
   );

   // Move the held item on when the result register is free or being taken
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_item.ready);
   assign req_item.ready = !in_valid_ff || advance;
   assign take_in        = req_item.valid && req_item.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_in) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_item_ff.run_switch  <= req_item.run_switch;
         in_item_ff.mode_switch <= req_item.mode_switch;
         in_item_ff.nozzle_jar  <= req_item.nozzle_jar;
         in_item_ff.press_jar   <= req_item.press_jar;
      end
   end

   // Sequencer state, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_item.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_item.valid          = out_valid_ff;
   assign rsp_item.motor_drive    = out_item_ff.motor_drive;
   assign rsp_item.twist_valve    = out_item_ff.twist_valve;
   assign rsp_item.press_valve    = out_item_ff.press_valve;
   assign rsp_item.extruder_on    = out_item_ff.extruder_on;
   assign rsp_item.led_all_jars   = out_item_ff.led_all_jars;
   assign rsp_item.led_first_only = out_item_ff.led_first_only;
   assign rsp_item.machine_on     = out_item_ff.machine_on;
   assign rsp_item.phase_code     = out_item_ff.phase_code;
   assign rsp_item.jar_index      = out_item_ff.jar_index;
   assign rsp_item.cap_index      = out_item_ff.cap_index;

   // Checks
   `JFC_ASSERT_SAME(a_full_blocks_input, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_item.ready, !req_item.ready,
      "input taken while both registers are full and the result is stalled")
   `JFC_ASSERT_NEXT(a_accept_fills_input, clock, reset,
      req_item.valid && req_item.ready, in_valid_ff,
      "accepted item not held in the input register")
   `JFC_ASSERT_SAME(a_press_needs_twist, clock, reset,
      rsp_item.valid && rsp_item.press_valve, rsp_item.twist_valve,
      "press cylinder driven without the twist cylinder")
   `JFC_ASSERT_SAME(a_extrude_stops_motor, clock, reset,
      rsp_item.valid && rsp_item.extruder_on, !rsp_item.motor_drive,
      "conveyor driven during extrusion")
   `JFC_ASSERT_SAME(a_lamps_exclusive, clock, reset,
      rsp_item.valid, rsp_item.led_all_jars != rsp_item.led_first_only,
      "mode lamps not exclusive")

endmodule

// ===== tb/tb_jar_fill_and_cap_station_sequencer.sv =====
// Testbench for the jar fill and cap station sequencer: drives tick items, predicts
// each result item (or takes it from the directed table) and compares it whole
// with the taken one. Needs jfc_pkg, the channel interfaces and the sequencer RTL.
`timescale 1ns / 1ps

module tb_jar_fill_and_cap_station_sequencer import jfc_pkg::*;;

   localparam int unsigned SET_SIZE = SET_SIZE_DEFAULT;
   localparam logic [POS_W-1:0] FIRST_JAR_LIMIT = 3'd1;
   localparam int unsigned HOLD_OFF_CYCLES = 40;

   // Phase codes as they appear on the result channel
   localparam logic [PHASE_CODE_W-1:0] CODE_IDLE       = 3'd0;
   localparam logic [PHASE_CODE_W-1:0] CODE_CENTER     = 3'd1;
   localparam logic [PHASE_CODE_W-1:0] CODE_EXTRUDE    = 3'd2;
   localparam logic [PHASE_CODE_W-1:0] CODE_TWIST_FWD  = 3'd3;
   localparam logic [PHASE_CODE_W-1:0] CODE_PRESS_FWD  = 3'd4;
   localparam logic [PHASE_CODE_W-1:0] CODE_PRESS_BACK = 3'd5;
   localparam logic [PHASE_CODE_W-1:0] CODE_TWIST_BACK = 3'd6;

   localparam logic [CFG_INDEX_W-1:0] REG_ORDER [8] = '{
      CFG_DEBOUNCE, CFG_POLL, CFG_CENTERING, CFG_EXTRUDE,
      CFG_TWIST_FORWARD, CFG_PRESS_FORWARD, CFG_PRESS_BACK, CFG_TWIST_BACK
   };

   // Running, all-jars mode, idle, both positions at zero
   localparam jfc_rsp_type RSP_RUN_IDLE = '{
      motor_drive: 1'b1, twist_valve: 1'b0, press_valve: 1'b0, extruder_on: 1'b0,
      led_all_jars: 1'b1, led_first_only: 1'b0, machine_on: 1'b1,
      phase_code: CODE_IDLE, jar_index: '0, cap_index: '0
   };
   localparam jfc_rsp_type FROM_MODEL = '0;

   typedef struct packed {
      jfc_req_type tick;
      logic        typed;
      jfc_rsp_type want;
   } tick_row_type;

   localparam int unsigned DIRECTED_AT_RESET = 4;
   localparam int unsigned DIRECTED_ROWS = 25;

   // Tick bits: run, mode, nozzle, press
   localparam tick_row_type DIRECTED [DIRECTED_ROWS] = '{
      // default timing straight after reset: nothing polls yet
      {4'b1000, 1'b1, RSP_RUN_IDLE},
      {4'b1000, 1'b1, RSP_RUN_IDLE},
      {4'b1100, 1'b1, RSP_RUN_IDLE},
      {4'b1010, 1'b1, RSP_RUN_IDLE},
      // zero poll, zero debounce, zero durations: full nozzle and press run
      {4'b1010, 1'b0, FROM_MODEL},
      {4'b1011, 1'b0, FROM_MODEL},
      {4'b1011, 1'b0, FROM_MODEL},
      {4'b1011, 1'b0, FROM_MODEL},
      {4'b1011, 1'b0, FROM_MODEL},
      {4'b1011, 1'b0, FROM_MODEL},
      {4'b1011, 1'b0, FROM_MODEL},
      {4'b1000, 1'b0, FROM_MODEL},
      // stop with mode resampled, then toggle mode while stopped
      {4'b0100, 1'b0, FROM_MODEL},
      {4'b0000, 1'b0, FROM_MODEL},
      {4'b0100, 1'b0, FROM_MODEL},
      // run in first-only mode and walk both positions round the set
      {4'b1100, 1'b0, FROM_MODEL},
      {4'b1110, 1'b0, FROM_MODEL},
      {4'b1101, 1'b0, FROM_MODEL},
      {4'b1110, 1'b0, FROM_MODEL},
      {4'b1101, 1'b0, FROM_MODEL},
      {4'b1110, 1'b0, FROM_MODEL},
      {4'b1101, 1'b0, FROM_MODEL},
      {4'b1110, 1'b0, FROM_MODEL},
      {4'b1101, 1'b0, FROM_MODEL},
      {4'b1111, 1'b0, FROM_MODEL}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CFG_INDEX_W-1:0] csr_index;
   logic [CFG_DATA_W-1:0]  csr_data;

   jfc_req_if req_ch();
   jfc_rsp_if rsp_ch();

   jar_fill_and_cap_station_sequencer #(.SET_SIZE(SET_SIZE)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_ch),
      .rsp_item  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predicted station state and timing registers
   jfc_state_type  station;
   logic [15:0]    timing [8];
   jfc_rsp_type    owed_outputs [$];
   int unsigned    bad_outputs = 0;
   bit             idle_on = 1'b1;
   bit             hold_off_request = 1'b0;
   bit             hold_off_done = 1'b0;
   logic           run_lvl = 1'b1;
   logic           mode_lvl = 1'b0;
   logic           noz_lvl = 1'b0;
   logic           prs_lvl = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [15:0] bump(logic [15:0] a);
      return (a == 16'hFFFF) ? a : a + 16'd1;
   endfunction

   function automatic logic [POS_W-1:0] advance_pos(logic [POS_W-1:0] p);
      int unsigned n;
      n = p + 1;
      if (n >= SET_SIZE) n = 0;
      return n[POS_W-1:0];
   endfunction

   // Press sensor check: first jar of a set starts the capping run
   task automatic sense_press(input logic jar);
      if (!station.press_busy_wait && jar) begin
         if (station.cap_position == '0) begin
            station.phase = PH_TWIST_FWD;
            station.phase_age = '0;
         end
         station.press_busy_wait = 1'b1;
         station.cap_position = advance_pos(station.cap_position);
      end
      if (station.press_busy_wait && !jar) station.press_busy_wait = 1'b0;
   endtask

   // Advance the station by one tick and work out its outputs
   task automatic step_station(input jfc_req_type t, output jfc_rsp_type r);
      logic [15:0] dur;
      if (station.phase != PH_IDLE) begin
         case (station.phase)
            PH_CENTER:     dur = timing[CFG_CENTERING];
            PH_EXTRUDE:    dur = timing[CFG_EXTRUDE];
            PH_TWIST_FWD:  dur = timing[CFG_TWIST_FORWARD];
            PH_PRESS_FWD:  dur = timing[CFG_PRESS_FORWARD];
            PH_PRESS_BACK: dur = timing[CFG_PRESS_BACK];
            default:       dur = timing[CFG_TWIST_BACK];
         endcase
         if (dur == 16'd0) dur = 16'd1;
         station.phase_age = bump(station.phase_age);
         if (station.phase_age >= dur) begin
            station.phase_age = '0;
            case (station.phase)
               PH_CENTER:     station.phase = PH_EXTRUDE;
               PH_EXTRUDE: begin
                  station.phase = PH_IDLE;
                  // the poll that started the nozzle run deferred this check
                  if (station.press_check_owed) begin
                     station.press_check_owed = 1'b0;
                     sense_press(t.press_jar);
                  end
               end
               PH_TWIST_FWD:  station.phase = PH_PRESS_FWD;
               PH_PRESS_FWD:  station.phase = PH_PRESS_BACK;
               PH_PRESS_BACK: station.phase = PH_TWIST_BACK;
               default:       station.phase = PH_IDLE;
            endcase
         end
      end else begin
         // lockout-debounced switches
         if (t.run_switch != station.run_level_seen &&
             station.run_lockout_age > timing[CFG_DEBOUNCE]) begin
            station.run_lockout_age = '0;
            station.run_level_seen = t.run_switch;
            station.running = t.run_switch;
         end
         if (!station.running && t.mode_switch != station.mode_level_seen &&
             station.mode_lockout_age > timing[CFG_DEBOUNCE]) begin
            station.mode_lockout_age = '0;
            station.mode_level_seen = t.mode_switch;
            station.first_only = t.mode_switch;
         end
         // take the mode over directly at the tick of stopping
         if (station.running_before && !station.running) begin
            station.first_only = t.mode_switch;
            station.mode_level_seen = t.mode_switch;
         end
         station.running_before = station.running;

         // sensor poll
         if (station.running && station.poll_age >= timing[CFG_POLL]) begin
            station.poll_age = '0;
            if (!station.nozzle_busy_wait && t.nozzle_jar) begin
               if (!(station.first_only && station.jar_position >= FIRST_JAR_LIMIT)) begin
                  station.phase = PH_CENTER;
                  station.phase_age = '0;
                  station.press_check_owed = 1'b1;
               end
               station.nozzle_busy_wait = 1'b1;
               station.jar_position = advance_pos(station.jar_position);
            end
            if (station.nozzle_busy_wait && !t.nozzle_jar) station.nozzle_busy_wait = 1'b0;
            if (!station.press_check_owed) sense_press(t.press_jar);
         end
      end

      r.motor_drive = (station.phase == PH_IDLE && station.running) ||
                      station.phase == PH_CENTER;
      r.twist_valve = station.phase == PH_TWIST_FWD || station.phase == PH_PRESS_FWD ||
                      station.phase == PH_PRESS_BACK;
      r.press_valve = station.phase == PH_PRESS_FWD;
      r.extruder_on = station.phase == PH_EXTRUDE;
      r.led_all_jars = !station.first_only;
      r.led_first_only = station.first_only;
      r.machine_on = station.running;
      case (station.phase)
         PH_CENTER:     r.phase_code = CODE_CENTER;
         PH_EXTRUDE:    r.phase_code = CODE_EXTRUDE;
         PH_TWIST_FWD:  r.phase_code = CODE_TWIST_FWD;
         PH_PRESS_FWD:  r.phase_code = CODE_PRESS_FWD;
         PH_PRESS_BACK: r.phase_code = CODE_PRESS_BACK;
         PH_TWIST_BACK: r.phase_code = CODE_TWIST_BACK;
         default:       r.phase_code = CODE_IDLE;
      endcase
      r.jar_index = station.jar_position;
      r.cap_index = station.cap_position;

      station.run_lockout_age = bump(station.run_lockout_age);
      station.mode_lockout_age = bump(station.mode_lockout_age);
      station.poll_age = bump(station.poll_age);
   endtask

   // Offer one tick item, hold it until taken, then maybe idle for a burst
   task automatic offer(input jfc_req_type t, input logic typed, input jfc_rsp_type want);
      jfc_rsp_type predicted;
      req_ch.valid <= 1'b1;
      req_ch.run_switch <= t.run_switch;
      req_ch.mode_switch <= t.mode_switch;
      req_ch.nozzle_jar <= t.nozzle_jar;
      req_ch.press_jar <= t.press_jar;
      do @(posedge clock); while (!req_ch.ready);
      step_station(t, predicted);
      owed_outputs.push_back(typed ? want : predicted);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed result has been taken
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (owed_outputs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all eight timing registers while nothing is in flight
   task automatic load_timing(input jfc_cfg_type c);
      logic [15:0] vals [8];
      vals = '{c.debounce_ticks, c.poll_ticks, c.centering_ticks, c.extrude_ticks,
               c.twist_forward_ticks, c.press_forward_ticks, c.press_back_ticks,
               c.twist_back_ticks};
      settle();
      for (int k = 0; k < 8; k++) begin
         csr_we <= 1'b1;
         csr_index <= REG_ORDER[k];
         csr_data <= vals[k];
         timing[REG_ORDER[k]] = vals[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Switches held for long stretches, sensors held across several polls
   task automatic run_random(input int unsigned count);
      jfc_req_type t;
      int unsigned lim;
      for (int unsigned i = 0; i < count; i++) begin
         lim = (timing[CFG_POLL] > 28) ? 30 : timing[CFG_POLL] + 2;
         if ($urandom_range(0, 39) == 0) run_lvl = ~run_lvl;
         if ($urandom_range(0, 14) == 0) mode_lvl = ~mode_lvl;
         if ($urandom_range(0, lim) == 0) noz_lvl = ~noz_lvl;
         if ($urandom_range(0, lim) == 0) prs_lvl = ~prs_lvl;
         t = {run_lvl, mode_lvl, noz_lvl, prs_lvl};
         // occasional noise tick
         if ($urandom_range(0, 15) == 0) t = 4'($urandom);
         offer(t, 1'b0, FROM_MODEL);
      end
   endtask

   function automatic jfc_cfg_type random_timing(int unsigned deb_hi, int unsigned poll_hi,
                                                 int unsigned dur_hi);
      jfc_cfg_type c;
      c.debounce_ticks = 16'($urandom_range(0, deb_hi));
      c.poll_ticks = 16'($urandom_range(0, poll_hi));
      c.centering_ticks = 16'($urandom_range(0, dur_hi));
      c.extrude_ticks = 16'($urandom_range(0, dur_hi));
      c.twist_forward_ticks = 16'($urandom_range(0, dur_hi));
      c.press_forward_ticks = 16'($urandom_range(0, dur_hi));
      c.press_back_ticks = 16'($urandom_range(0, dur_hi));
      c.twist_back_ticks = 16'($urandom_range(0, dur_hi));
      return c;
   endfunction

   // Receiver: random hold-off bursts, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each taken result with the oldest owed one
   always @(posedge clock) begin
      jfc_rsp_type got;
      jfc_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.motor_drive, rsp_ch.twist_valve, rsp_ch.press_valve,
                rsp_ch.extruder_on, rsp_ch.led_all_jars, rsp_ch.led_first_only,
                rsp_ch.machine_on, rsp_ch.phase_code, rsp_ch.jar_index, rsp_ch.cap_index};
         if (owed_outputs.size() == 0) begin
            if (bad_outputs < 10) $display("result with no tick waiting: got %p", got);
            bad_outputs++;
         end else begin
            want = owed_outputs.pop_front();
            if (got !== want) begin
               if (bad_outputs < 10) $display("result mismatch: expected %p, got %p", want, got);
               bad_outputs++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CFG_DEBOUNCE;
      csr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.run_switch <= 1'b0;
      req_ch.mode_switch <= 1'b0;
      req_ch.nozzle_jar <= 1'b0;
      req_ch.press_jar <= 1'b0;
      station = STATE_RESET;
      timing[CFG_DEBOUNCE] = DEBOUNCE_RESET;
      timing[CFG_POLL] = POLL_RESET;
      timing[CFG_CENTERING] = PNEU_RESET;
      timing[CFG_EXTRUDE] = EXTRUDE_RESET;
      timing[CFG_TWIST_FORWARD] = PNEU_RESET;
      timing[CFG_PRESS_FORWARD] = PNEU_RESET;
      timing[CFG_PRESS_BACK] = PNEU_RESET;
      timing[CFG_TWIST_BACK] = PNEU_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table, fast timing after the first rows
      for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == DIRECTED_AT_RESET)
            load_timing('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
         offer(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);
      end

      // fill the block while the receiver holds off
      hold_off_request = 1'b1;
      run_random(80);

      load_timing('{16'd3, 16'd2, 16'd2, 16'd3, 16'd1, 16'd2, 16'd1, 16'd2});
      run_random(80);

      load_timing(random_timing(8, 5, 6));
      run_random(80);

      // top of every range: switches locked out, no polls, endless phases
      load_timing('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      run_random(40);

      load_timing(random_timing(6, 4, 6));
      run_random(100);

      // last stretch without idling on either side
      load_timing('{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1});
      idle_on = 1'b0;
      run_random(60);

      settle();
      repeat (4) @(posedge clock);
      if (bad_outputs == 0 && owed_outputs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
